// ===== hw/rtl/tnnt_pkg.sv =====
// ----------------------------------------------------------------------------
// tnnt_pkg
// Shared constants, payload types and controller/datapath signal groups for
// the two-nearest-neighbour triangle block.
// ----------------------------------------------------------------------------
package tnnt_pkg;

  localparam int MAX_POINTS = 2048;
  localparam int COORD_BITS = 16;

  localparam int ADDR_W  = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int POINT_W = 3 * COORD_BITS;
  localparam int MAG_W   = COORD_BITS;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;

  // Field widths fixed by the interface
  localparam int IDX_W   = 11;
  localparam int POS_W   = 16;
  localparam int REG_W   = 34;
  localparam int CMP_W   = (SUM_W > REG_W) ? SUM_W : REG_W;

  // APB-style port: 64-bit data, registers on 8-byte boundaries
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;

  localparam logic [REG_W-1:0] MIN_DIST_RST = REG_W'(1000);
  localparam logic [REG_W-1:0] MAX_DIST_RST = REG_W'(16000);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  // Register select is paddr bit 3 (8-byte spacing)
  typedef enum logic {
    REG_MIN_DIST = 1'b0,
    REG_MAX_DIST = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0]        query_point;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_point;
    logic             found;
    logic [IDX_W-1:0] nearest_index;
    logic [IDX_W-1:0] second_index;
  } out_item_t;

  typedef struct packed {
    logic load_we;      // append input point
    logic count_clr;    // empty the store
    logic q_latch;      // capture query index, clear best pair
    logic rd_centre;    // read address is the query index
    logic centre_latch; // read data holds the query point
    logic scan_issue;   // issue one scan read
    logic res_latch;    // load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic store_full;
    logic q_in_range;
    logic scan_last;
    logic pipe_empty;
  } dp_sts_t;

endpackage

// ===== hw/rtl/tnnt_ram.sv =====
// ----------------------------------------------------------------------------
// tnnt_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module tnnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tnnt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tnnt_ctrl
// Sequencer: request decode, query scan sequencing, result hand-off.
// ----------------------------------------------------------------------------
module tnnt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  output logic              out_valid,
  input  logic              out_ready,
  output tnnt_pkg::dp_cmd_t cmd,
  input  tnnt_pkg::dp_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CENTRE = 5'b00010,
    S_CWAIT  = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DRAIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (tnnt_pkg::op_t'(in_opcode))
            tnnt_pkg::OP_LOAD: begin
              cmd.load_we = !sts.store_full;
            end
            tnnt_pkg::OP_CLEAR: begin
              cmd.count_clr = 1'b1;
            end
            tnnt_pkg::OP_QUERY: begin
              cmd.q_latch = 1'b1;
              state_nxt   = S_CENTRE;
            end
            default: ;
          endcase
        end
      end
      S_CENTRE: begin
        cmd.rd_centre = 1'b1;
        state_nxt     = sts.q_in_range ? S_CWAIT : S_DRAIN;
      end
      S_CWAIT: begin
        cmd.centre_latch = 1'b1;
        state_nxt        = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty && (!out_valid_r || out_ready)) begin
          cmd.res_latch = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.res_latch) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/tnnt_dp.sv =====
// ----------------------------------------------------------------------------
// tnnt_dp
// Datapath: point store, point count, scan counter, four-stage distance
// pipeline, best-pair tracker and result register.
// ----------------------------------------------------------------------------
module tnnt_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tnnt_pkg::in_item_t               in_data,
  input  logic [tnnt_pkg::REG_W-1:0]       min_dist_sq,
  input  logic [tnnt_pkg::REG_W-1:0]       max_dist_sq,
  input  tnnt_pkg::dp_cmd_t                cmd,
  output tnnt_pkg::dp_sts_t                sts,
  output tnnt_pkg::out_item_t              out_data
);

  localparam int CB = tnnt_pkg::COORD_BITS;

  typedef logic [tnnt_pkg::MAG_W-1:0] mag_t;

  function automatic mag_t abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic signed [CB:0] d;
    logic signed [CB:0] m;
    begin
      d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
      m = d[CB] ? -d : d;
      return m[tnnt_pkg::MAG_W-1:0];
    end
  endfunction

  // Store and count
  logic [tnnt_pkg::CNT_W-1:0]   count_r;
  logic [tnnt_pkg::ADDR_W-1:0]  raddr;
  logic [tnnt_pkg::POINT_W-1:0] wdata, rdata;

  // Query control
  logic [tnnt_pkg::IDX_W-1:0]   q_r;
  logic [tnnt_pkg::POINT_W-1:0] centre_r;
  logic [tnnt_pkg::CNT_W-1:0]   scan_j_r;

  // Pipeline
  logic                         p1_vld_r, p2_vld_r, p3_vld_r, p4_vld_r;
  logic [tnnt_pkg::ADDR_W-1:0]  p1_idx_r, p2_idx_r, p3_idx_r, p4_idx_r;
  logic                         p2_eq_r, p3_eq_r, p4_eq_r;
  mag_t                         p2_mx_r, p2_my_r, p2_mz_r;
  logic [tnnt_pkg::SQ_W-1:0]    p3_sx_r, p3_sy_r, p3_sz_r;
  logic [tnnt_pkg::CMP_W-1:0]   p4_d_r;

  // Best pair
  logic                         v1_r, v2_r;
  logic [tnnt_pkg::CMP_W-1:0]   d1_r, d2_r;
  logic [tnnt_pkg::ADDR_W-1:0]  i1_r, i2_r;
  logic                         qual, beat1, beat2;

  tnnt_pkg::out_item_t          out_r;

  assign wdata = {in_data.pos_x[CB-1:0], in_data.pos_y[CB-1:0], in_data.pos_z[CB-1:0]};
  assign raddr = cmd.rd_centre ? tnnt_pkg::ADDR_W'(q_r)
                               : scan_j_r[tnnt_pkg::ADDR_W-1:0];

  tnnt_ram #(
    .WIDTH (tnnt_pkg::POINT_W),
    .DEPTH (tnnt_pkg::MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr (count_r[tnnt_pkg::ADDR_W-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sts.store_full = (32'(count_r) >= tnnt_pkg::MAX_POINTS);
  assign sts.q_in_range = (32'(q_r) < 32'(count_r));
  assign sts.scan_last  = (scan_j_r == count_r - tnnt_pkg::CNT_W'(1));
  assign sts.pipe_empty = !(p1_vld_r || p2_vld_r || p3_vld_r || p4_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.count_clr) begin
      count_r <= '0;
    end else if (cmd.load_we) begin
      count_r <= count_r + tnnt_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_latch) begin
      q_r <= in_data.query_point;
    end
    if (cmd.centre_latch) begin
      centre_r <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_j_r <= '0;
    end else if (cmd.q_latch) begin
      scan_j_r <= '0;
    end else if (cmd.scan_issue) begin
      scan_j_r <= scan_j_r + tnnt_pkg::CNT_W'(1);
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      p4_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= cmd.scan_issue;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
    end
  end

  // Stage payloads: read tag, abs diffs, squares, sum
  always_ff @(posedge clk) begin
    p1_idx_r <= scan_j_r[tnnt_pkg::ADDR_W-1:0];

    p2_idx_r <= p1_idx_r;
    p2_eq_r  <= (rdata == centre_r);
    p2_mx_r  <= abs_diff(rdata[3*CB-1:2*CB], centre_r[3*CB-1:2*CB]);
    p2_my_r  <= abs_diff(rdata[2*CB-1:CB],   centre_r[2*CB-1:CB]);
    p2_mz_r  <= abs_diff(rdata[CB-1:0],      centre_r[CB-1:0]);

    p3_idx_r <= p2_idx_r;
    p3_eq_r  <= p2_eq_r;
    p3_sx_r  <= p2_mx_r * p2_mx_r;
    p3_sy_r  <= p2_my_r * p2_my_r;
    p3_sz_r  <= p2_mz_r * p2_mz_r;

    p4_idx_r <= p3_idx_r;
    p4_eq_r  <= p3_eq_r;
    p4_d_r   <= tnnt_pkg::CMP_W'(p3_sx_r) + tnnt_pkg::CMP_W'(p3_sy_r)
              + tnnt_pkg::CMP_W'(p3_sz_r);
  end

  // Best-pair update; a new nearest pushes the old one to second place
  assign qual  = p4_vld_r && !p4_eq_r
              && (p4_d_r > tnnt_pkg::CMP_W'(min_dist_sq))
              && (p4_d_r <= tnnt_pkg::CMP_W'(max_dist_sq));
  assign beat1 = !v1_r || (p4_d_r < d1_r);
  assign beat2 = !v2_r || (p4_d_r < d2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (cmd.q_latch) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (qual) begin
      if (beat1) begin
        v1_r <= 1'b1;
        v2_r <= v1_r || v2_r;
      end else if (beat2) begin
        v2_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (qual) begin
      if (beat1) begin
        d1_r <= p4_d_r;
        i1_r <= p4_idx_r;
        if (v1_r) begin
          d2_r <= d1_r;
          i2_r <= i1_r;
        end
      end else if (beat2) begin
        d2_r <= p4_d_r;
        i2_r <= p4_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_latch) begin
      out_r.result_point  <= q_r;
      out_r.found         <= v1_r && v2_r;
      out_r.nearest_index <= (v1_r && v2_r) ? tnnt_pkg::IDX_W'(i1_r) : '0;
      out_r.second_index  <= (v1_r && v2_r) ? tnnt_pkg::IDX_W'(i2_r) : '0;
    end
  end

  assign out_data = out_r;

endmodule

// ===== hw/rtl/two_nearest_neighbour_triangle_top.sv =====
// ----------------------------------------------------------------------------
// two_nearest_neighbour_triangle_top
// Point store with brute-force two-nearest-neighbour search per query.
// ----------------------------------------------------------------------------
// Load and clear requests: done on acceptance, ready stays high for the next request.
// Query: centre read, one store read per stored point through a single read port,
//   four-stage distance pipe drain, then the result is registered and the next
//   request is taken; a waiting result holds it off.
// Out-of-range query index: no scan, the result is reported with found clear.
// Reset (rst_n low, synchronous) empties the store count and restores the
//   distance bounds to 1000 and 16000; store contents are not cleared.
module two_nearest_neighbour_triangle_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tnnt_pkg::in_item_t                  in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output tnnt_pkg::out_item_t                 out_data,
  // configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tnnt_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [tnnt_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [tnnt_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  // Distance bounds: min exclusive, max inclusive, squared units
  logic [tnnt_pkg::REG_W-1:0] min_dist_r, min_dist_nxt;
  logic [tnnt_pkg::REG_W-1:0] max_dist_r, max_dist_nxt;
  logic                       cfg_wr;
  tnnt_pkg::reg_sel_t         cfg_sel;

  tnnt_pkg::dp_cmd_t cmd;
  tnnt_pkg::dp_sts_t sts;

  // Write strobe on the access phase; pready is tied high so no wait states
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = tnnt_pkg::reg_sel_t'(cfg_paddr[3]);

  always_comb begin
    min_dist_nxt = min_dist_r;
    max_dist_nxt = max_dist_r;
    if (cfg_wr) begin
      unique case (cfg_sel)
        tnnt_pkg::REG_MIN_DIST: min_dist_nxt = cfg_pwdata[tnnt_pkg::REG_W-1:0];
        tnnt_pkg::REG_MAX_DIST: max_dist_nxt = cfg_pwdata[tnnt_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= tnnt_pkg::MIN_DIST_RST;
      max_dist_r <= tnnt_pkg::MAX_DIST_RST;
    end else begin
      min_dist_r <= min_dist_nxt;
      max_dist_r <= max_dist_nxt;
    end
  end

  // Read-back mux, bounds zero-extended to the bus
  always_comb begin
    unique case (cfg_sel)
      tnnt_pkg::REG_MIN_DIST: cfg_prdata = tnnt_pkg::CFG_DATA_W'(min_dist_r);
      tnnt_pkg::REG_MAX_DIST: cfg_prdata = tnnt_pkg::CFG_DATA_W'(max_dist_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // Sequencer: takes requests only when idle, holds result valid
  tnnt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_data.opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Store, distance pipe, best-pair tracker, result register
  tnnt_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .min_dist_sq (min_dist_r),
    .max_dist_sq (max_dist_r),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (out_data)
  );

endmodule

// ===== hw/rtl/tnnt_checker.sv =====
// ----------------------------------------------------------------------------
// tnnt_checker
// Port-level checks on the triangle block, bound to the top level.
// ----------------------------------------------------------------------------
module tnnt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input tnnt_pkg::out_item_t             out_data
);

  // Result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // No neighbours reported without a triangle
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      out_data.nearest_index == '0 && out_data.second_index == '0)
    else $error("indices set on a result without a triangle");

  // A triangle has two distinct neighbours
  a_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.nearest_index != out_data.second_index)
    else $error("nearest and second nearest coincide");

  // Reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind two_nearest_neighbour_triangle_top tnnt_checker u_tnnt_checker (.*);

// ===== tb/triangle_check_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_check_pkg
// Scoreboard for the two-nearest-neighbour triangle block: keeps its own copy
// of the point store and distance bounds and queues the triangle each query
// should report.
// ----------------------------------------------------------------------------
package triangle_check_pkg;

  import tnnt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  class triangle_scoreboard;

    logic signed [POS_W-1:0] store_x [MAX_POINTS];
    logic signed [POS_W-1:0] store_y [MAX_POINTS];
    logic signed [POS_W-1:0] store_z [MAX_POINTS];
    int unsigned             point_total;
    logic [REG_W-1:0]        lower_sq;
    logic [REG_W-1:0]        upper_sq;
    out_item_t               pending_triangles [$];
    int unsigned             fault_count;

    function new();
      point_total = 0;
      lower_sq    = MIN_DIST_RST;
      upper_sq    = MAX_DIST_RST;
      fault_count = 0;
    endfunction

    function void set_bound(reg_sel_t sel, logic [REG_W-1:0] value);
      if (sel == REG_MIN_DIST) lower_sq = value;
      else upper_sq = value;
    endfunction

    function int pending();
      return pending_triangles.size();
    endfunction

    function void flag_fault(string msg);
      fault_count++;
      if (fault_count <= 10) $display("MISMATCH %0t: %s", $time, msg);
    endfunction

    // Accepted request: update the store or work out the triangle.
    function void note_request(in_item_t req);
      longint      dx, dy, dz, d, best_d, next_d;
      bit          have_best, have_next;
      int unsigned best_i, next_i, q;
      out_item_t   tri_res;
      case (req.opcode)
        OP_LOAD: begin
          if (point_total < MAX_POINTS) begin
            store_x[point_total] = req.pos_x;
            store_y[point_total] = req.pos_y;
            store_z[point_total] = req.pos_z;
            point_total++;
          end
        end
        OP_CLEAR: point_total = 0;
        OP_QUERY: begin
          have_best = 0;
          have_next = 0;
          best_d    = 0;
          next_d    = 0;
          best_i    = 0;
          next_i    = 0;
          q         = req.query_point;
          if (q < point_total) begin
            for (int j = 0; j < point_total; j++) begin
              if (store_x[j] == store_x[q] && store_y[j] == store_y[q] &&
                  store_z[j] == store_z[q]) continue;
              dx = longint'(store_x[j]) - longint'(store_x[q]);
              dy = longint'(store_y[j]) - longint'(store_y[q]);
              dz = longint'(store_z[j]) - longint'(store_z[q]);
              d  = dx * dx + dy * dy + dz * dz;
              if (d <= longint'(lower_sq) || d > longint'(upper_sq)) continue;
              if (!have_best || d < best_d) begin
                if (have_best) begin
                  have_next = 1;
                  next_d    = best_d;
                  next_i    = best_i;
                end
                have_best = 1;
                best_d    = d;
                best_i    = j;
              end else if (!have_next || d < next_d) begin
                have_next = 1;
                next_d    = d;
                next_i    = j;
              end
            end
          end
          tri_res.result_point  = req.query_point;
          tri_res.found         = have_best && have_next;
          tri_res.nearest_index = tri_res.found ? IDX_W'(best_i) : '0;
          tri_res.second_index  = tri_res.found ? IDX_W'(next_i) : '0;
          pending_triangles.push_back(tri_res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_triangles.size() == 0) begin
        flag_fault($sformatf("unexpected result: point %0d found %0d nearest %0d second %0d",
                             got.result_point, got.found, got.nearest_index,
                             got.second_index));
        return;
      end
      want = pending_triangles.pop_front();
      if (got.result_point !== want.result_point || got.found !== want.found ||
          got.nearest_index !== want.nearest_index ||
          got.second_index !== want.second_index)
        flag_fault($sformatf({"expected point %0d found %0d nearest %0d second %0d, ",
                              "got point %0d found %0d nearest %0d second %0d"},
                             want.result_point, want.found, want.nearest_index,
                             want.second_index, got.result_point, got.found,
                             got.nearest_index, got.second_index));
    endfunction

  endclass

endpackage

// ===== tb/two_nearest_neighbour_triangle_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_nearest_neighbour_triangle_top_tb
// Drives load, clear and query requests into the triangle block under several
// distance-bound settings, with random stalls on both channels, and checks
// every reported triangle against the scoreboard's own nearest-pair search.
// ----------------------------------------------------------------------------
module two_nearest_neighbour_triangle_top_tb;

  import tnnt_pkg::*;
  import triangle_check_pkg::*;

  // Longest quiet stretch: a query on a small store behind the long hold-off
  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 300;  // long result-side hold-off
  localparam int SETTLE_CYCLES = 16;   // lets trailing loads/clears finish
  localparam int TAIL_CYCLES   = 40;
  localparam logic [REG_W-1:0] BOUND_MAX = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  triangle_scoreboard sb = new();

  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  bit          hold_req;
  int unsigned quiet_cycles;

  two_nearest_neighbour_triangle_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold-off on request so
  // the block fills and stalls its request channel.
  // --------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog: only cycles with no handshake on any port count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side. Called at a falling edge; returns at the falling edge after
  // acceptance with valid still high, so back-to-back requests drop it only in random idle gaps.
  // --------------------------------------------------------------------------
  task automatic send_request(in_item_t req);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    @(negedge clk);
  endtask

  function automatic in_item_t make_request(logic [1:0] op, int x, int y, int z,
                                            int unsigned q);
    in_item_t req;
    req.opcode      = op;
    req.pos_x       = POS_W'(x);
    req.pos_y       = POS_W'(y);
    req.pos_z       = POS_W'(z);
    req.query_point = IDX_W'(q);
    return req;
  endfunction

  function automatic logic signed [POS_W-1:0] jitter(logic signed [POS_W-1:0] c,
                                                     int spread);
    return POS_W'(int'(c) + int'($urandom_range(2 * spread)) - spread);
  endfunction

  // Wait for every triangle to arrive, then let any trailing load settle
  task automatic wait_store_idle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write followed by a read-back; setup then access phase each
  task automatic cfg_write(reg_sel_t sel, logic [REG_W-1:0] value);
    logic [CFG_DATA_W-1:0] readback;
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {sel, 3'b000};
    cfg_pwdata  = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_bound(sel, value);
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    if (readback !== CFG_DATA_W'(value))
      sb.flag_fault($sformatf("register %0d read back %0h, wrote %0h", sel, readback,
                              value));
  endtask

  task automatic set_bounds(logic [REG_W-1:0] lo, logic [REG_W-1:0] hi);
    wait_store_idle();
    cfg_write(REG_MIN_DIST, lo);
    cfg_write(REG_MAX_DIST, hi);
  endtask

  // Random traffic: mostly tight clusters around a random centre so that
  // queries find neighbours inside the window, mixed with clears, unused
  // opcodes, out-of-range indices and full-range points.
  task automatic random_traffic(int n_requests);
    in_item_t                req;
    int unsigned             pick;
    int                      spread;
    logic signed [POS_W-1:0] cx, cy, cz;
    cx     = POS_W'($urandom);
    cy     = POS_W'($urandom);
    cz     = POS_W'($urandom);
    spread = $urandom_range(20, 90);
    repeat (n_requests) begin
      req.opcode      = OP_LOAD;
      req.pos_x       = POS_W'($urandom);
      req.pos_y       = POS_W'($urandom);
      req.pos_z       = POS_W'($urandom);
      req.query_point = IDX_W'($urandom);
      pick = $urandom_range(99);
      if (sb.point_total >= 40 || pick < 7) begin
        // keep the store small so queries stay short; start a new cluster
        req.opcode = OP_CLEAR;
        cx     = POS_W'($urandom);
        cy     = POS_W'($urandom);
        cz     = POS_W'($urandom);
        spread = $urandom_range(20, 90);
      end else if (pick < 11) begin
        req.opcode = OP_UNUSED;
      end else if (pick < 40) begin
        req.opcode = OP_QUERY;
        if (sb.point_total > 0 && $urandom_range(9) != 0)
          req.query_point = IDX_W'($urandom_range(sb.point_total - 1));
      end else if ($urandom_range(9) != 0) begin
        req.pos_x = jitter(cx, spread);
        req.pos_y = jitter(cy, spread);
        req.pos_z = jitter(cz, spread);
      end
      send_request(req);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    rst_n        = 1'b0;
    hold_req     = 1'b0;
    in_idle_pct  = 10;
    out_idle_pct = 63;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset bounds 1000 < d <= 16000, centre at the origin
    send_request(make_request(OP_LOAD, 0, 0, 0, 0));
    send_request(make_request(OP_LOAD, 30, 10, 0, 0));     // d = 1000, lower bound out
    send_request(make_request(OP_LOAD, 0, 40, 0, 0));      // d = 1600
    send_request(make_request(OP_LOAD, 0, 0, -50, 0));     // d = 2500
    send_request(make_request(OP_LOAD, 0, 0, 0, 0));       // same coordinates, skipped
    send_request(make_request(OP_LOAD, -40, 0, 0, 0));     // ties the nearest
    send_request(make_request(OP_LOAD, 0, 127, 0, 0));     // d = 16129, above upper
    send_request(make_request(OP_LOAD, 120, 40, 0, 0));   // d = 16000, upper bound in
    send_request(make_request(OP_QUERY, 0, 0, 0, 0));
    send_request(make_request(OP_QUERY, 0, 0, 0, 4));
    send_request(make_request(OP_QUERY, 0, 0, 0, 7));
    send_request(make_request(OP_LOAD, 32767, 32767, 32767, 2047));
    send_request(make_request(OP_LOAD, -32768, -32768, -32768, 0));
    send_request(make_request(OP_QUERY, 0, 0, 0, 9));
    send_request(make_request(OP_QUERY, 0, 0, 0, 10));     // index equals count
    send_request(make_request(OP_QUERY, -1, -1, -1, 2047));
    send_request(make_request(OP_UNUSED, -1, -1, -1, 2047));
    send_request(make_request(OP_CLEAR, 0, 0, 0, 0));
    send_request(make_request(OP_QUERY, 0, 0, 0, 0));      // empty store
    send_request(make_request(OP_LOAD, 5, 5, 5, 0));
    send_request(make_request(OP_LOAD, 5, 5, 45, 0));
    send_request(make_request(OP_QUERY, 0, 0, 0, 0));      // one neighbour only

    // Every distance accepted
    set_bounds('0, BOUND_MAX);
    send_request(make_request(OP_CLEAR, 0, 0, 0, 0));

    // Sender idles lightly, receiver heavily
    random_traffic(45);
    set_bounds(BOUND_MAX, BOUND_MAX);
    random_traffic(30);

    // Roles swapped
    in_idle_pct  = 63;
    out_idle_pct = 10;
    set_bounds('0, '0);
    random_traffic(30);
    set_bounds(REG_W'(200), REG_W'(20000));
    random_traffic(50);

    // No idling; long result hold-off while requests keep coming
    in_idle_pct  = 0;
    out_idle_pct = 0;
    set_bounds(REG_W'($urandom_range(5000)), '0);
    set_bounds(sb.lower_sq, sb.lower_sq + REG_W'($urandom_range(30000)));
    hold_req = 1'b1;
    random_traffic(60);
    set_bounds(MIN_DIST_RST, MAX_DIST_RST);
    random_traffic(60);

    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fault_count == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
